[hdl/cubic_bezier_point_normal_assert.svh]
// Assertion macros for the cubic Bezier point and normal block.
`ifndef CUBIC_BEZIER_POINT_NORMAL_ASSERT_SVH
`define CUBIC_BEZIER_POINT_NORMAL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBPN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/cbpn_pkg.sv]
// Shared constants and types for the cubic Bezier point and normal block.
package cbpn_pkg;

	localparam int COORD_BITS_DEF  = 24;
	localparam int T_FRAC_BITS_DEF = 16;
	localparam int NORM_FRAC       = 14;
	localparam int NORM_W          = 16;
	localparam int MAG_W           = 30;
	localparam int ROOT_W          = 31;
	localparam int SQ_W            = 2 * ROOT_W;
	localparam int REM_W           = ROOT_W + 2;
	localparam int QUO_W           = NORM_FRAC + 1;
	localparam int NUM_W           = MAG_W + NORM_FRAC + 2;
	localparam int DEN_W           = ROOT_W + 1;

	localparam logic [QUO_W-1:0] NORM_ONE = QUO_W'(1) << NORM_FRAC;

	typedef struct packed {
		logic zero;
		logic nx_neg;
		logic ny_neg;
	} nside_t;

endpackage

[hdl/cubic_bezier_point_normal.sv]
// Top level: cubic Bezier point and unit normal, fully pipelined.
//
// Input channel: in_valid/in_ready carry four control points and param_t.
// Output channel: out_valid/out_ready carry the point and the unit normal.
// A transfer happens on a clock edge where valid and ready are both high.
// One item can enter every cycle unless the output stalls; the pipeline keeps one sample per stage.
// From input transfer to output valid a sample passes 3 interpolation stages,
// 4 scaling/square stages, 31 square-root stages (one root bit each), 16 divider
// stages (an input register, then one quotient bit each) and the output register.
// The square-root and divider chains set the depth.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or duplicated.
// Bubbles are not squeezed out, so a stalled output holds up to 55 items.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
// A zero derivative gives a zero normal.
`include "cubic_bezier_point_normal_assert.svh"

module cubic_bezier_point_normal
	import cbpn_pkg::*;
#(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by_coord,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic signed [COORD_BITS-1:0] dx_pt,
	input  logic signed [COORD_BITS-1:0] dy_pt,
	input  logic [T_FRAC_BITS:0]         param_t,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y,
	output logic signed [NORM_W-1:0]     normal_x,
	output logic signed [NORM_W-1:0]     normal_y
);

	localparam int PW  = 2 * COORD_BITS;
	localparam int SW  = $bits(nside_t);
	localparam int IW  = 2 * MAG_W + SW + PW;
	localparam int DCW = SW + PW;

	logic en;
	logic v_s5;

	assign en       = !v_s5 || out_ready;
	assign in_ready = en;

	logic                         cst_v;
	logic signed [COORD_BITS-1:0] cst_px, cst_py;
	logic signed [COORD_BITS:0]   cst_dx, cst_dy;

	cbpn_casteljau #(.CB(COORD_BITS), .TB(T_FRAC_BITS)) u_casteljau (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(in_valid && in_ready),
		.ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord),
		.cx(cx), .cy(cy), .dx_pt(dx_pt), .dy_pt(dy_pt), .param_t(param_t),
		.out_v(cst_v), .pt_x(cst_px), .pt_y(cst_py), .d_x(cst_dx), .d_y(cst_dy)
	);

	logic              prp_v;
	logic [MAG_W-1:0]  prp_mx, prp_my;
	logic [SQ_W-1:0]   prp_sum;
	nside_t            prp_side;
	logic [PW-1:0]     prp_pts;

	cbpn_prep #(.CB(COORD_BITS), .CW(PW)) u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(cst_v),
		.d_x(cst_dx), .d_y(cst_dy), .carry_in({cst_px, cst_py}),
		.out_v(prp_v), .mag_x(prp_mx), .mag_y(prp_my), .sum(prp_sum),
		.side(prp_side), .carry_out(prp_pts)
	);

	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	logic [IW-1:0]     sq_carry;
	logic [MAG_W-1:0]  sq_mx, sq_my;
	nside_t            sq_side;
	logic [PW-1:0]     sq_pts;

	cbpn_isqrt #(.CW(IW)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(prp_v), .sq(prp_sum),
		.carry_in({prp_mx, prp_my, prp_side, prp_pts}),
		.out_v(sq_v), .root(sq_root), .carry_out(sq_carry)
	);

	assign {sq_mx, sq_my, sq_side, sq_pts} = sq_carry;

	logic             dv_v;
	logic [QUO_W-1:0] dv_qx, dv_qy;
	logic [DCW-1:0]   dv_carry;
	nside_t           dv_side;
	logic [PW-1:0]    dv_pts;

	// normal_x follows |dy|, normal_y follows |dx|
	cbpn_div #(.CW(DCW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sq_v),
		.mag_a(sq_my), .mag_b(sq_mx), .root(sq_root),
		.carry_in({sq_side, sq_pts}),
		.out_v(dv_v), .quo_a(dv_qx), .quo_b(dv_qy), .carry_out(dv_carry)
	);

	assign {dv_side, dv_pts} = dv_carry;

	logic [QUO_W-1:0]  sat_x, sat_y;
	logic [NORM_W-1:0] nx_w, ny_w;

	always_comb begin
		sat_x = (dv_qx > NORM_ONE) ? NORM_ONE : dv_qx;
		sat_y = (dv_qy > NORM_ONE) ? NORM_ONE : dv_qy;
		nx_w  = dv_side.nx_neg ? (~NORM_W'(sat_x) + 1'b1) : NORM_W'(sat_x);
		ny_w  = dv_side.ny_neg ? (~NORM_W'(sat_y) + 1'b1) : NORM_W'(sat_y);
		if (dv_side.zero) begin
			nx_w = '0;
			ny_w = '0;
		end
	end

	logic [COORD_BITS-1:0] px_s5, py_s5;
	logic [NORM_W-1:0]     nx_s5, ny_s5;
	logic                  zero_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			{px_s5, py_s5} <= dv_pts;
			nx_s5          <= nx_w;
			ny_s5          <= ny_w;
			zero_s5        <= dv_side.zero;
		end
	end

	assign out_valid = v_s5;
	assign point_x   = $signed(px_s5);
	assign point_y   = $signed(py_s5);
	assign normal_x  = $signed(nx_s5);
	assign normal_y  = $signed(ny_s5);

	`CBPN_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(point_x) && $stable(point_y) && $stable(normal_x) && $stable(normal_y), "result changed while waiting for out_ready")
	`CBPN_ASSERT_NOW(a_root_normalized, clk, arst_n, sq_v && !sq_side.zero, sq_root[ROOT_W-1:MAG_W-1] != '0, "square root below normalized range")
	`CBPN_ASSERT_NOW(a_normal_nonzero, clk, arst_n, out_valid && !zero_s5, (normal_x != '0) || (normal_y != '0), "nonzero derivative gave zero normal")
	`CBPN_ASSERT_NOW(a_normal_range, clk, arst_n, out_valid, (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384) && (normal_y <= 16'sd16384) && (normal_y >= -16'sd16384), "normal out of range")

endmodule

[hdl/cbpn_casteljau.sv]
// Three-level de Casteljau interpolation: curve point and derivative direction.
module cbpn_casteljau
	import cbpn_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF,
	parameter int TB = T_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic signed [CB-1:0] ax,
	input  logic signed [CB-1:0] ay,
	input  logic signed [CB-1:0] bx,
	input  logic signed [CB-1:0] by_coord,
	input  logic signed [CB-1:0] cx,
	input  logic signed [CB-1:0] cy,
	input  logic signed [CB-1:0] dx_pt,
	input  logic signed [CB-1:0] dy_pt,
	input  logic [TB:0]          param_t,
	output logic                 out_v,
	output logic signed [CB-1:0] pt_x,
	output logic signed [CB-1:0] pt_y,
	output logic signed [CB:0]   d_x,
	output logic signed [CB:0]   d_y
);

	localparam logic [TB:0] T_ONE = (TB+1)'(1) << TB;
	localparam logic [CB+TB+2:0] HALF = (CB+TB+3)'(1) << (TB-1);

	// a + round((b - a) * t), tie toward plus infinity
	function automatic logic [CB-1:0] lerp(input logic [CB-1:0] a, input logic [CB-1:0] b,
		input logic [TB:0] t);
		logic signed [CB:0]      diff;
		logic signed [CB+TB+2:0] prod;
		diff = $signed({b[CB-1], b}) - $signed({a[CB-1], a});
		prod = diff * $signed({1'b0, t});
		prod = prod + $signed(HALF);
		return a + prod[CB+TB-1:TB];
	endfunction

	logic [TB:0] t_in;
	assign t_in = (param_t > T_ONE) ? T_ONE : param_t;

	logic          v_s1, v_s2, v_s3;
	logic [TB:0]   t_s1, t_s2;
	logic [CB-1:0] qx_s1 [3];
	logic [CB-1:0] qy_s1 [3];
	logic [CB-1:0] rx_s2 [2];
	logic [CB-1:0] ry_s2 [2];
	logic [CB-1:0] px_s3, py_s3;
	logic [CB:0]   dx_s3, dy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= t_in;
			qx_s1[0] <= lerp(ax, bx, t_in);
			qx_s1[1] <= lerp(bx, cx, t_in);
			qx_s1[2] <= lerp(cx, dx_pt, t_in);
			qy_s1[0] <= lerp(ay, by_coord, t_in);
			qy_s1[1] <= lerp(by_coord, cy, t_in);
			qy_s1[2] <= lerp(cy, dy_pt, t_in);
			t_s2     <= t_s1;
			rx_s2[0] <= lerp(qx_s1[0], qx_s1[1], t_s1);
			rx_s2[1] <= lerp(qx_s1[1], qx_s1[2], t_s1);
			ry_s2[0] <= lerp(qy_s1[0], qy_s1[1], t_s1);
			ry_s2[1] <= lerp(qy_s1[1], qy_s1[2], t_s1);
			px_s3    <= lerp(rx_s2[0], rx_s2[1], t_s2);
			py_s3    <= lerp(ry_s2[0], ry_s2[1], t_s2);
			dx_s3    <= {rx_s2[1][CB-1], rx_s2[1]} - {rx_s2[0][CB-1], rx_s2[0]};
			dy_s3    <= {ry_s2[1][CB-1], ry_s2[1]} - {ry_s2[0][CB-1], ry_s2[0]};
		end
	end

	assign out_v = v_s3;
	assign pt_x  = $signed(px_s3);
	assign pt_y  = $signed(py_s3);
	assign d_x   = $signed(dx_s3);
	assign d_y   = $signed(dy_s3);

endmodule

[hdl/cbpn_prep.sv]
// Derivative magnitude, block scaling to [2^29, 2^30) and sum of squares.
module cbpn_prep
	import cbpn_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF,
	parameter int CW = 2 * COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic signed [CB:0] d_x,
	input  logic signed [CB:0] d_y,
	input  logic [CW-1:0]      carry_in,
	output logic               out_v,
	output logic [MAG_W-1:0]   mag_x,
	output logic [MAG_W-1:0]   mag_y,
	output logic [SQ_W-1:0]    sum,
	output nside_t             side,
	output logic [CW-1:0]      carry_out
);

	localparam int DW    = CB + 1;
	localparam int MSB_W = $clog2(DW);
	localparam int XW    = DW + MAG_W;

	logic [DW-1:0]    abs_x, abs_y, m_w;
	logic [MSB_W-1:0] msb_w;
	nside_t           side_w;

	always_comb begin
		abs_x = d_x[DW-1] ? (~d_x + 1'b1) : d_x;
		abs_y = d_y[DW-1] ? (~d_y + 1'b1) : d_y;
		m_w   = (abs_x > abs_y) ? abs_x : abs_y;
		msb_w = '0;
		for (int i = 0; i < DW; i++) begin
			if (m_w[i]) msb_w = MSB_W'(i);
		end
		side_w.zero   = (d_x == '0) && (d_y == '0);
		side_w.nx_neg = !d_y[DW-1] && (d_y != '0);
		side_w.ny_neg = d_x[DW-1];
	end

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [DW-1:0]      mx_s1, my_s1;
	logic [MSB_W-1:0]   msb_s1;
	nside_t             side_s1, side_s2, side_s3, side_s4;
	logic [CW-1:0]      c_s1, c_s2, c_s3, c_s4;
	logic [MAG_W-1:0]   mx_s2, my_s2, mx_s3, my_s3, mx_s4, my_s4;
	logic [2*MAG_W-1:0] sqx_s3, sqy_s3;
	logic [SQ_W-1:0]    sum_s4;

	logic [XW-1:0] ext_x, ext_y, sh_x, sh_y;

	always_comb begin
		ext_x = XW'(mx_s1);
		ext_y = XW'(my_s1);
		if (int'(msb_s1) >= MAG_W) begin
			sh_x = ext_x >> (int'(msb_s1) - (MAG_W - 1));
			sh_y = ext_y >> (int'(msb_s1) - (MAG_W - 1));
		end else begin
			sh_x = ext_x << ((MAG_W - 1) - int'(msb_s1));
			sh_y = ext_y << ((MAG_W - 1) - int'(msb_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= abs_x;
			my_s1   <= abs_y;
			msb_s1  <= msb_w;
			side_s1 <= side_w;
			c_s1    <= carry_in;
			mx_s2   <= sh_x[MAG_W-1:0];
			my_s2   <= sh_y[MAG_W-1:0];
			side_s2 <= side_s1;
			c_s2    <= c_s1;
			sqx_s3  <= mx_s2 * mx_s2;
			sqy_s3  <= my_s2 * my_s2;
			mx_s3   <= mx_s2;
			my_s3   <= my_s2;
			side_s3 <= side_s2;
			c_s3    <= c_s2;
			sum_s4  <= SQ_W'(sqx_s3) + SQ_W'(sqy_s3);
			mx_s4   <= mx_s3;
			my_s4   <= my_s3;
			side_s4 <= side_s3;
			c_s4    <= c_s3;
		end
	end

	assign out_v     = v_s4;
	assign mag_x     = mx_s4;
	assign mag_y     = my_s4;
	assign sum       = sum_s4;
	assign side      = side_s4;
	assign carry_out = c_s4;

endmodule

[hdl/cbpn_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module cbpn_isqrt
	import cbpn_pkg::*;
#(
	parameter int CW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [SQ_W-1:0]   sq,
	input  logic [CW-1:0]     carry_in,
	output logic              out_v,
	output logic [ROOT_W-1:0] root,
	output logic [CW-1:0]     carry_out
);

	logic              v_s    [ROOT_W+1];
	logic [REM_W-1:0]  rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	logic [SQ_W-1:0]   sq_s   [ROOT_W+1];
	logic [CW-1:0]     c_s    [ROOT_W+1];

	assign v_s[0]    = in_v;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sq_s[0]   = sq;
	assign c_s[0]    = carry_in;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		logic [REM_W-1:0] rem_sh, trial;
		logic             hit;

		always_comb begin
			rem_sh = {rem_s[g][REM_W-3:0], sq_s[g][SQ_W-1-2*g -: 2]};
			trial  = {root_s[g], 2'b01};
			hit    = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= hit ? (rem_sh - trial) : rem_sh;
				root_s[g+1] <= {root_s[g][ROOT_W-2:0], hit};
				sq_s[g+1]   <= sq_s[g];
				c_s[g+1]    <= c_s[g];
			end
		end
	end

	assign out_v     = v_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign carry_out = c_s[ROOT_W];

endmodule

[hdl/cbpn_div.sv]
// Pipelined restoring divider for both normal components: round(mag * 2^14 / root).
module cbpn_div
	import cbpn_pkg::*;
#(
	parameter int CW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [MAG_W-1:0]  mag_a,
	input  logic [MAG_W-1:0]  mag_b,
	input  logic [ROOT_W-1:0] root,
	input  logic [CW-1:0]     carry_in,
	output logic              out_v,
	output logic [QUO_W-1:0]  quo_a,
	output logic [QUO_W-1:0]  quo_b,
	output logic [CW-1:0]     carry_out
);

	logic             v_s   [QUO_W+1];
	logic [NUM_W-1:0] ra_s  [QUO_W+1];
	logic [NUM_W-1:0] rb_s  [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0] qa_s  [QUO_W+1];
	logic [QUO_W-1:0] qb_s  [QUO_W+1];
	logic [CW-1:0]    c_s   [QUO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	// numerator carries the half-divisor for round to nearest
	always_ff @(posedge clk) begin
		if (en) begin
			ra_s[0]  <= NUM_W'({mag_a, {(NORM_FRAC+1){1'b0}}}) + NUM_W'(root);
			rb_s[0]  <= NUM_W'({mag_b, {(NORM_FRAC+1){1'b0}}}) + NUM_W'(root);
			den_s[0] <= {root, 1'b0};
			qa_s[0]  <= '0;
			qb_s[0]  <= '0;
			c_s[0]   <= carry_in;
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_stage
		logic [NUM_W-1:0] dsh;
		logic             hit_a, hit_b;

		always_comb begin
			dsh   = NUM_W'(den_s[g]) << (QUO_W - 1 - g);
			hit_a = ra_s[g] >= dsh;
			hit_b = rb_s[g] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[g+1]  <= hit_a ? (ra_s[g] - dsh) : ra_s[g];
				rb_s[g+1]  <= hit_b ? (rb_s[g] - dsh) : rb_s[g];
				qa_s[g+1]  <= qa_s[g] | (QUO_W'(hit_a) << (QUO_W - 1 - g));
				qb_s[g+1]  <= qb_s[g] | (QUO_W'(hit_b) << (QUO_W - 1 - g));
				den_s[g+1] <= den_s[g];
				c_s[g+1]   <= c_s[g];
			end
		end
	end

	assign out_v     = v_s[QUO_W];
	assign quo_a     = qa_s[QUO_W];
	assign quo_b     = qb_s[QUO_W];
	assign carry_out = c_s[QUO_W];

endmodule
